FILE: src/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared constants and types of the sparse set slot table
// Table sizes, operation and status codes, and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int ENTITY_SLOTS = 256;
	localparam int DENSE_SLOTS  = 256;
	localparam int HANDLE_BITS  = 32;

	localparam int IDX_BITS   = $clog2(ENTITY_SLOTS);
	localparam int SLOT_BITS  = $clog2(DENSE_SLOTS);
	localparam int COUNT_BITS = SLOT_BITS + 1;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_HAS    = 2'd2;
	localparam logic [1:0] OP_GET    = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_PRESENT = 2'd1;
	localparam logic [1:0] STAT_ABSENT  = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic capture;  // latch the word and launch the table reads
		logic commit;   // update the tables and load the result register
	} sst_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_blocked;  // result register full and not being taken
	} sst_stat_t;

endpackage

FILE: src/sst_ctrl.sv
// ----------------------------------------------------------------------------
// sst_ctrl: operation sequencer
// Two-step controller: capture a word with the table reads, then commit
// the table updates once the result register can take the answer.
// ----------------------------------------------------------------------------
module sst_ctrl import sst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  sst_stat_t stat,
	output sst_cmd_t  cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold while the previous result still waits
				if (!stat.out_blocked) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/sst_datapath.sv
// ----------------------------------------------------------------------------
// sst_datapath: tables, entry count and result register
// Holds the sparse map (valid flops plus slot memory), the dense handle and
// owner memories, the occupied count and the registered result word.
// ----------------------------------------------------------------------------
module sst_datapath import sst_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sst_cmd_t               cmd,
	output sst_stat_t              stat,
	input  logic [1:0]             op,
	input  logic [IDX_BITS-1:0]    entity_index,
	input  logic [HANDLE_BITS-1:0] entity_handle,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic                   present,
	output logic [SLOT_BITS-1:0]   slot,
	output logic                   moved,
	output logic [SLOT_BITS-1:0]   moved_from,
	output logic [COUNT_BITS-1:0]  entry_count
);

	// captured word
	logic [1:0]             op_q;
	logic [IDX_BITS-1:0]    idx_q;
	logic [HANDLE_BITS-1:0] handle_q;

	// table state
	logic [ENTITY_SLOTS-1:0] valid_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [SLOT_BITS-1:0]    sparse_mem [ENTITY_SLOTS];
	logic [HANDLE_BITS-1:0]  dense_handle_mem [DENSE_SLOTS];
	logic [IDX_BITS-1:0]     dense_owner_mem [DENSE_SLOTS];

	// registered read data
	logic [SLOT_BITS-1:0]   sparse_rd_q;
	logic [HANDLE_BITS-1:0] last_handle_q;
	logic [IDX_BITS-1:0]    last_owner_q;

	// result register
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic                  present_q;
	logic [SLOT_BITS-1:0]  slot_q;
	logic                  moved_q;
	logic [SLOT_BITS-1:0]  moved_from_q;
	logic [COUNT_BITS-1:0] count_out_q;

	// execute-step decode
	logic                   here;
	logic [SLOT_BITS-1:0]   cur;
	logic [COUNT_BITS-1:0]  last;
	logic [SLOT_BITS-1:0]   last_slot;
	logic                   full;
	logic                   add_ok;
	logic                   rem_ok;
	logic                   do_move;
	logic [1:0]             res_status;
	logic                   res_present;
	logic [SLOT_BITS-1:0]   res_slot;
	logic [COUNT_BITS-1:0]  count_d;
	logic                   sparse_we;
	logic [IDX_BITS-1:0]    sparse_waddr;
	logic [SLOT_BITS-1:0]   sparse_wdata;
	logic                   dense_we;
	logic [SLOT_BITS-1:0]   dense_waddr;
	logic [HANDLE_BITS-1:0] dense_whandle;
	logic [IDX_BITS-1:0]    dense_wowner;

	assign here      = valid_q[idx_q];
	assign cur       = here ? sparse_rd_q : '0;
	assign last      = count_q - COUNT_BITS'(1);
	assign last_slot = last[SLOT_BITS-1:0];
	assign full      = (count_q >= COUNT_BITS'(DENSE_SLOTS));

	always_comb begin
		add_ok      = 1'b0;
		rem_ok      = 1'b0;
		res_status  = STAT_OK;
		res_present = 1'b0;
		res_slot    = '0;
		unique case (op_q)
			OP_ADD: begin
				if (here) begin
					res_status  = STAT_PRESENT;
					res_present = 1'b1;
					res_slot    = cur;
				end else if (full) begin
					res_status = STAT_FULL;
				end else begin
					add_ok   = 1'b1;
					res_slot = count_q[SLOT_BITS-1:0];
				end
			end
			OP_REMOVE: begin
				if (here) begin
					rem_ok      = 1'b1;
					res_present = 1'b1;
					res_slot    = cur;
				end else begin
					res_status = STAT_ABSENT;
				end
			end
			OP_HAS: begin
				res_present = here;
				res_slot    = cur;
			end
			OP_GET: begin
				if (here) begin
					res_present = 1'b1;
					res_slot    = cur;
				end else begin
					res_status = STAT_ABSENT;
				end
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
	end

	// a remove that frees an inner slot pulls the last entry down into it
	assign do_move = rem_ok && (cur != last_slot);

	always_comb begin
		count_d = count_q;
		if (add_ok) begin
			count_d = count_q + COUNT_BITS'(1);
		end else if (rem_ok) begin
			count_d = last;
		end
	end

	// one write port per memory
	assign sparse_we     = cmd.commit && (add_ok || do_move);
	assign sparse_waddr  = add_ok ? idx_q : last_owner_q;
	assign sparse_wdata  = add_ok ? count_q[SLOT_BITS-1:0] : cur;
	assign dense_we      = cmd.commit && (add_ok || do_move);
	assign dense_waddr   = add_ok ? count_q[SLOT_BITS-1:0] : cur;
	assign dense_whandle = add_ok ? handle_q : last_handle_q;
	assign dense_wowner  = add_ok ? idx_q : last_owner_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op;
			idx_q    <= entity_index;
			handle_q <= entity_handle;
		end
	end

	always_ff @(posedge clk) begin
		if (sparse_we) begin
			sparse_mem[sparse_waddr] <= sparse_wdata;
		end
		if (cmd.capture) begin
			sparse_rd_q <= sparse_mem[entity_index];
		end
	end

	always_ff @(posedge clk) begin
		if (dense_we) begin
			dense_handle_mem[dense_waddr] <= dense_whandle;
			dense_owner_mem[dense_waddr]  <= dense_wowner;
		end
		if (cmd.capture) begin
			last_handle_q <= dense_handle_mem[last_slot];
			last_owner_q  <= dense_owner_mem[last_slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.commit) begin
			if (add_ok) begin
				valid_q[idx_q] <= 1'b1;
			end else if (rem_ok) begin
				valid_q[idx_q] <= 1'b0;
			end
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q     <= res_status;
			present_q    <= res_present;
			slot_q       <= res_slot;
			moved_q      <= do_move;
			moved_from_q <= do_move ? last_slot : '0;
			count_out_q  <= count_d;
		end
	end

	assign stat.out_blocked = out_valid_q && !out_ready;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign present     = present_q;
	assign slot        = slot_q;
	assign moved       = moved_q;
	assign moved_from  = moved_from_q;
	assign entry_count = count_out_q;

endmodule

FILE: src/sparse_set_slot_table.sv
// ----------------------------------------------------------------------------
// sparse_set_slot_table: sparse set mapping entity indices to dense slots
// Add, remove (swap the last entry into the freed slot), has and get, with
// duplicate, absent and full reported in the status field.
// ----------------------------------------------------------------------------
//
//  channel  handshake             fields
//  -------  --------------------  ----------------------------------------------
//  in       in_valid / in_ready   op, entity_index, entity_handle
//  out      out_valid / out_ready status, present, slot, moved, moved_from,
//                                 entry_count
//
//  Every word takes two steps: the accept cycle launches the sparse-map
//  read and the read of the last dense entry in parallel, the commit step
//  uses the registered read data to commit all table writes at once.
//  The two registered memory reads ahead of the dependent writes set the rate.
//  Reset clears the sparse valid flops and the count at once; no clearing
//  pass. The dense memories need no reset since only written slots are read.
//  A result waits in the output register while the next word is accepted;
//  the commit of that word holds until the output register is taken.
//
module sparse_set_slot_table import sst_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             op,
	input  logic [IDX_BITS-1:0]    entity_index,
	input  logic [HANDLE_BITS-1:0] entity_handle,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             status,
	output logic                   present,
	output logic [SLOT_BITS-1:0]   slot,
	output logic                   moved,
	output logic [SLOT_BITS-1:0]   moved_from,
	output logic [COUNT_BITS-1:0]  entry_count
);

	sst_cmd_t  cmd;
	sst_stat_t stat;

	// sequencer: capture, then commit when the output register is free
	sst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// tables, count and result register
	sst_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.op            (op),
		.entity_index  (entity_index),
		.entity_handle (entity_handle),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.present       (present),
		.slot          (slot),
		.moved         (moved),
		.moved_from    (moved_from),
		.entry_count   (entry_count)
	);

	// an accepted word is never followed by another accept in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word accepted during execute step");

	// a move only comes from a successful remove, from a different slot
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && moved |-> status == STAT_OK && present && moved_from != slot)
		else $error("inconsistent move report");

	// the count never passes the dense capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= COUNT_BITS'(DENSE_SLOTS))
		else $error("entry count over capacity");

	// a commit never overwrites a result that is still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid && !out_ready))
		else $error("result overwritten");

endmodule

FILE: tb/sv/sst_result_checker.sv
// ----------------------------------------------------------------------------
// sst_result_checker: result predictor and scoreboard for the slot table
// Tracks the sparse map, the dense slot owners and the entry count, works
// out the reply to each accepted input word and compares every accepted
// result word with the oldest reply still due.
// ----------------------------------------------------------------------------
module sst_result_checker import sst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [1:0]            op,
	input  logic [IDX_BITS-1:0]   entity_index,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [1:0]            status,
	input  logic                  present,
	input  logic [SLOT_BITS-1:0]  slot,
	input  logic                  moved,
	input  logic [SLOT_BITS-1:0]  moved_from,
	input  logic [COUNT_BITS-1:0] entry_count,
	output int unsigned           fail_count,
	output int unsigned           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]            status;
		logic                  present;
		logic [SLOT_BITS-1:0]  slot;
		logic                  moved;
		logic [SLOT_BITS-1:0]  moved_from;
		logic [COUNT_BITS-1:0] entry_count;
	} slot_reply_t;

	logic                  linked   [ENTITY_SLOTS];
	logic [SLOT_BITS-1:0]  slot_of  [ENTITY_SLOTS];
	logic [IDX_BITS-1:0]   owner_of [DENSE_SLOTS];
	logic [COUNT_BITS-1:0] count;
	slot_reply_t           replies_due [$];
	int unsigned           mismatches;

	// Apply one operation to the shadow tables and return its reply.
	function automatic slot_reply_t apply_op(input logic [1:0] code,
			input logic [IDX_BITS-1:0] idx);
		slot_reply_t          r;
		logic [SLOT_BITS-1:0] cur;
		logic [SLOT_BITS-1:0] last;
		logic [IDX_BITS-1:0]  mover;
		r = '0;
		cur = linked[idx] ? slot_of[idx] : '0;
		case (code)
			OP_ADD: begin
				if (linked[idx]) begin
					r.status = STAT_PRESENT;
					r.present = 1'b1;
					r.slot = cur;
				end else if (count >= COUNT_BITS'(DENSE_SLOTS)) begin
					r.status = STAT_FULL;
				end else begin
					r.status = STAT_OK;
					r.slot = count[SLOT_BITS-1:0];
					linked[idx] = 1'b1;
					slot_of[idx] = count[SLOT_BITS-1:0];
					owner_of[count[SLOT_BITS-1:0]] = idx;
					count = count + 1'b1;
				end
			end
			OP_REMOVE: begin
				if (!linked[idx] || count == '0) begin
					r.status = STAT_ABSENT;
				end else begin
					last = SLOT_BITS'(count - 1'b1);
					if (cur != last) begin
						// swap the last dense entry into the hole
						mover = owner_of[last];
						owner_of[cur] = mover;
						slot_of[mover] = cur;
						r.moved = 1'b1;
						r.moved_from = last;
					end
					linked[idx] = 1'b0;
					slot_of[idx] = '0;
					count = count - 1'b1;
					r.status = STAT_OK;
					r.present = 1'b1;
					r.slot = cur;
				end
			end
			OP_HAS: begin
				r.status = STAT_OK;
				r.present = linked[idx];
				r.slot = cur;
			end
			default: begin
				if (linked[idx]) begin
					r.status = STAT_OK;
					r.present = 1'b1;
					r.slot = cur;
				end else begin
					r.status = STAT_ABSENT;
				end
			end
		endcase
		r.entry_count = count;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		slot_reply_t due;
		if (!arst_n) begin
			for (int i = 0; i < ENTITY_SLOTS; i++) begin
				linked[i] = 1'b0;
				slot_of[i] = '0;
			end
			for (int i = 0; i < DENSE_SLOTS; i++)
				owner_of[i] = '0;
			count = '0;
			replies_due.delete();
			mismatches = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// retire the result first; it always belongs to an older word
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					mismatches++;
					$display("%0t ns: result expected none, got status %0d slot %0d count %0d",
						$time, status, slot, entry_count);
				end else begin
					due = replies_due.pop_front();
					check_field("status", due.status, status);
					check_field("present", due.present, present);
					check_field("slot", due.slot, slot);
					check_field("moved", due.moved, moved);
					check_field("moved_from", due.moved_from, moved_from);
					check_field("entry_count", due.entry_count, entry_count);
				end
			end
			if (in_valid && in_ready)
				replies_due.push_back(apply_op(op, entity_index));
			fail_count <= mismatches;
			outstanding <= replies_due.size();
		end
	end

endmodule

FILE: tb/sv/tb_sparse_set_slot_table.sv
// ----------------------------------------------------------------------------
// tb_sparse_set_slot_table: testbench of the sparse set slot table
// Drives a directed opening and a phased random run (narrow mixing, fill to
// a full table, drain, wide mixing) with random gaps on both channels, and
// leaves prediction and comparison to the result checker beside the block.
// ----------------------------------------------------------------------------
module tb_sparse_set_slot_table;
	timeunit 1ns;
	timeprecision 1ps;

	import sst_pkg::*;

	localparam int CLK_PERIOD    = 20;
	localparam int RESET_CYCLES  = 9;
	localparam int RANDOM_WORDS  = 550;
	localparam int NARROW_WORDS  = 100;
	localparam int CALM_WORDS    = 80;
	localparam int FULL_WORDS    = 12;
	localparam int SETTLE_CYCLES = 8;
	localparam int STALL_LIMIT   = 2000;

	typedef enum {MIX_NARROW, FILL_UP, DRAIN_DOWN, MIX_WIDE} phase_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [1:0]             op;
	logic [IDX_BITS-1:0]    entity_index;
	logic [HANDLE_BITS-1:0] entity_handle;
	logic                   out_valid;
	logic                   out_ready;
	logic [1:0]             status;
	logic                   present;
	logic [SLOT_BITS-1:0]   slot;
	logic                   moved;
	logic [SLOT_BITS-1:0]   moved_from;
	logic [COUNT_BITS-1:0]  entry_count;
	int unsigned            fail_count;
	int unsigned            outstanding;

	// Which indices the stimulus believes are mapped; used only to steer
	// the random part toward hits, fills and drains.
	logic [ENTITY_SLOTS-1:0] held;
	int                      live;
	// Sender gaps on or off for the current stretch; calm turns off all
	// idling on both sides for the tail of the run.
	logic                    pauses_on;
	logic                    calm;

	sparse_set_slot_table i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.entity_index (entity_index),
		.entity_handle(entity_handle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.present      (present),
		.slot         (slot),
		.moved        (moved),
		.moved_from   (moved_from),
		.entry_count  (entry_count)
	);

	sst_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.entity_index(entity_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.present     (present),
		.slot        (slot),
		.moved       (moved),
		.moved_from  (moved_from),
		.entry_count (entry_count),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Offer one word, hold it until the block takes it, then track the
	// mapping it causes and maybe insert an idle burst.
	task automatic send_word(input logic [1:0] code, input logic [IDX_BITS-1:0] idx,
			input logic [HANDLE_BITS-1:0] handle);
		in_valid <= 1'b1;
		op <= code;
		entity_index <= idx;
		entity_handle <= handle;
		do @(posedge clk); while (!in_ready);
		case (code)
			OP_ADD: begin
				if (!held[idx] && live < DENSE_SLOTS) begin
					held[idx] = 1'b1;
					live++;
				end
			end
			OP_REMOVE: begin
				if (held[idx]) begin
					held[idx] = 1'b0;
					live--;
				end
			end
			default: ;
		endcase
		// an idle burst drops valid; without one the next word follows back to back
		if (!calm && pauses_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Hold off the sender until every reply in flight has come back.
	task automatic wait_results_in();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Pick a random index that is mapped (want_held) or free; the caller
	// makes sure one exists.
	function automatic logic [IDX_BITS-1:0] pick_index(input logic want_held);
		logic [IDX_BITS-1:0] k;
		k = IDX_BITS'($urandom_range(0, ENTITY_SLOTS - 1));
		for (int n = 0; n < ENTITY_SLOTS && held[k] != want_held; n++)
			k = k + 1'b1;
		return k;
	endfunction

	// Receiver: random stalls between ready stretches of varying length,
	// none once the run turns calm.
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	// Watchdog: end the run if no word moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("tb_sparse_set_slot_table NOT OK");
				$finish;
			end
		end
	end

	initial begin
		phase_t              phase;
		logic [1:0]          code;
		logic [IDX_BITS-1:0] idx;
		int                  roll;
		int                  full_words;
		logic                full_drained;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_ADD;
		entity_index <= '0;
		entity_handle <= '0;
		held = '0;
		live = 0;
		pauses_on = 1'b1;
		calm = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening: lookups on an empty table, adds at both ends of
		// the index range with extreme handles, a duplicate add, a remove that
		// swaps the last entry in, a remove of the last slot and absent removes.
		send_word(OP_GET, 8'd0, 32'h0000_0000);
		send_word(OP_REMOVE, 8'd255, 32'hFFFF_FFFF);
		send_word(OP_HAS, 8'd7, 32'h0000_0000);
		send_word(OP_ADD, 8'd0, 32'h0000_0000);
		send_word(OP_ADD, 8'd255, 32'hFFFF_FFFF);
		send_word(OP_ADD, 8'd0, 32'h1234_5678);
		send_word(OP_ADD, 8'd128, 32'h5A5A_A5A5);
		send_word(OP_HAS, 8'd255, 32'h0000_0000);
		send_word(OP_GET, 8'd128, 32'hFFFF_FFFF);
		send_word(OP_REMOVE, 8'd0, 32'h0000_0000);
		send_word(OP_GET, 8'd128, 32'h0000_0000);
		send_word(OP_HAS, 8'd0, 32'h0000_0000);
		send_word(OP_REMOVE, 8'd255, 32'h0000_0000);
		send_word(OP_REMOVE, 8'd255, 32'h0000_0000);
		send_word(OP_REMOVE, 8'd128, 32'hFFFF_FFFF);
		send_word(OP_HAS, 8'd128, 32'h0000_0000);
		send_word(OP_GET, 8'd255, 32'h0000_0000);

		// drain everything before the random run starts
		wait_results_in();

		phase = MIX_NARROW;
		full_words = 0;
		full_drained = 1'b0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 32 == 0)
				pauses_on = ($urandom_range(0, 2) != 0);
			calm = (n >= RANDOM_WORDS - CALM_WORDS);
			roll = $urandom_range(0, 99);
			code = 2'($urandom_range(0, 3));
			idx = IDX_BITS'($urandom());
			case (phase)
				MIX_NARROW: begin
					// crowd a few indices so hits and duplicates are common
					if (roll < 85)
						idx = IDX_BITS'($urandom_range(0, 15));
				end
				FILL_UP: begin
					if (live == DENSE_SLOTS) begin
						// every index is mapped: adds can only collide
						if (roll < 50)
							code = OP_ADD;
						else if (roll < 75)
							code = OP_HAS;
						else
							code = OP_GET;
						full_words++;
					end else if (roll < 88) begin
						code = OP_ADD;
						idx = pick_index(1'b0);
					end
				end
				DRAIN_DOWN: begin
					if (live > 0 && roll < 75) begin
						code = OP_REMOVE;
						idx = pick_index(1'b1);
					end
				end
				default: ;
			endcase
			send_word(code, idx, $urandom());

			// advance the phase
			case (phase)
				MIX_NARROW: if (n + 1 >= NARROW_WORDS) phase = FILL_UP;
				FILL_UP: begin
					if (live == DENSE_SLOTS && !full_drained) begin
						full_drained = 1'b1;
						wait_results_in();
					end
					if (full_words >= FULL_WORDS)
						phase = DRAIN_DOWN;
				end
				DRAIN_DOWN: if (live == 0) phase = MIX_WIDE;
				default: ;
			endcase
		end

		wait_results_in();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_sparse_set_slot_table OK");
		else
			$display("tb_sparse_set_slot_table NOT OK");
		$finish;
	end

endmodule
